// ----- design/bmc_pkg.sv -----
package bmc_pkg;

  // counter width default and fixed level table size
  localparam int TIMER_BITS_DEF = 16;
  localparam int LEVEL_COUNT    = 16;

  localparam logic [6:0] RAW_FALLBACK = 7'd56;
  localparam logic [6:0] RAW_RESET    = 7'd56;

  // action codes
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_ON     = 3'd1;
  localparam logic [2:0] ACT_OFF    = 3'd2;
  localparam logic [2:0] ACT_BLINK  = 3'd3;
  localparam logic [2:0] ACT_TOGGLE = 3'd4;
  localparam logic [2:0] ACT_LEVEL  = 3'd5;

  // target codes
  localparam logic [1:0] TGT_SCREEN = 2'd0;
  localparam logic [1:0] TGT_KEYS   = 2'd1;
  localparam logic [1:0] TGT_BOTH   = 2'd2;
  localparam logic [1:0] TGT_NONE   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_BLINK_ARG = 2'd1;
  localparam logic [1:0] ERR_TARGET    = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  target;
    logic [15:0] duration;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [4:0]  level;
  } bmc_in_t;

  typedef struct packed {
    logic       screen_lit;
    logic       keys_lit;
    logic       screen_blinking;
    logic       keys_blinking;
    logic [6:0] brightness_raw;
    logic [4:0] brightness_step;
    logic [1:0] error_code;
  } bmc_out_t;

  // per channel control from the decoder
  typedef struct packed {
    logic       tick;
    logic       sel;
    logic [2:0] kind;
    logic       pre_sw;
  } bmc_chan_ctl_t;

  // per channel status back to the top
  typedef struct packed {
    logic hold_fire;
    logic blink_fire;
    logic lit_nxt;
    logic blink_nxt;
  } bmc_chan_sts_t;

  // brightness status back to the top
  typedef struct packed {
    logic       hold_fire;
    logic [6:0] raw_nxt;
    logic [4:0] step_nxt;
  } bmc_bright_sts_t;

  function automatic logic [6:0] level_to_raw(input logic [3:0] idx);
    logic [6:0] r;
    unique case (idx)
      4'd0:    r = 7'd0;
      4'd1:    r = 7'd13;
      4'd2:    r = 7'd17;
      4'd3:    r = 7'd23;
      4'd4:    r = 7'd29;
      4'd5:    r = 7'd35;
      4'd6:    r = 7'd41;
      4'd7:    r = 7'd47;
      4'd8:    r = 7'd53;
      4'd9:    r = 7'd59;
      4'd10:   r = 7'd65;
      4'd11:   r = 7'd71;
      4'd12:   r = 7'd77;
      4'd13:   r = 7'd83;
      4'd14:   r = 7'd89;
      default: r = 7'd100;
    endcase
    return r;
  endfunction

  // lower bound of each readback level
  function automatic logic [6:0] raw_threshold(input logic [3:0] idx);
    logic [6:0] r;
    unique case (idx)
      4'd0:    r = 7'd0;
      4'd1:    r = 7'd13;
      4'd2:    r = 7'd14;
      4'd3:    r = 7'd18;
      4'd4:    r = 7'd24;
      4'd5:    r = 7'd30;
      4'd6:    r = 7'd36;
      4'd7:    r = 7'd42;
      4'd8:    r = 7'd48;
      4'd9:    r = 7'd54;
      4'd10:   r = 7'd60;
      4'd11:   r = 7'd66;
      4'd12:   r = 7'd72;
      4'd13:   r = 7'd78;
      4'd14:   r = 7'd84;
      default: r = 7'd90;
    endcase
    return r;
  endfunction

  // thresholds rise monotonically, so the level is one plus the count passed
  function automatic logic [4:0] raw_to_step(input logic [6:0] raw);
    logic [4:0] cnt;
    cnt = 5'd1;
    for (int i = 1; i < LEVEL_COUNT; i++) begin
      if (raw >= raw_threshold(4'(i))) begin
        cnt = cnt + 5'd1;
      end
    end
    return cnt;
  endfunction

endpackage

// ----- design/bmc_if.sv -----
interface bmc_in_if;
  logic              valid;
  logic              ready;
  bmc_pkg::bmc_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmc_out_if;
  logic              valid;
  logic              ready;
  bmc_pkg::bmc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/bmc_chan.sv -----
module bmc_chan #(
  parameter int TIMER_BITS = bmc_pkg::TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   upd,
  input  bmc_pkg::bmc_chan_ctl_t ctl,
  input  logic [TIMER_BITS-1:0]  dur,
  input  logic [TIMER_BITS-1:0]  on_t,
  input  logic [TIMER_BITS-1:0]  off_t,
  output bmc_pkg::bmc_chan_sts_t sts
);

  localparam logic [TIMER_BITS-1:0] ONE = TIMER_BITS'(1);

  logic                  lit_r, lit_nxt;
  logic                  blink_r, blink_nxt;
  logic [TIMER_BITS-1:0] on_r, on_nxt;
  logic [TIMER_BITS-1:0] off_r, off_nxt;
  logic                  sv_lit_r, sv_lit_nxt;
  logic                  sv_blink_r, sv_blink_nxt;
  logic [TIMER_BITS-1:0] sv_on_r, sv_on_nxt;
  logic [TIMER_BITS-1:0] sv_off_r, sv_off_nxt;
  logic [TIMER_BITS-1:0] hold_r, hold_nxt;
  logic [TIMER_BITS-1:0] cnt_r, cnt_nxt;
  logic                  hold_fire;
  logic                  blink_fire;

  assign hold_fire  = (hold_r == ONE);
  assign blink_fire = (cnt_r == ONE);

  always_comb begin
    lit_nxt      = lit_r;
    blink_nxt    = blink_r;
    on_nxt       = on_r;
    off_nxt      = off_r;
    sv_lit_nxt   = sv_lit_r;
    sv_blink_nxt = sv_blink_r;
    sv_on_nxt    = sv_on_r;
    sv_off_nxt   = sv_off_r;
    hold_nxt     = hold_r;
    cnt_nxt      = cnt_r;
    if (ctl.tick) begin
      hold_nxt = (hold_r != '0) ? hold_r - ONE : '0;
      if (hold_fire) begin
        // fall back to the saved mode, pending blink expiry is dropped
        lit_nxt   = sv_lit_r;
        blink_nxt = sv_blink_r;
        on_nxt    = sv_on_r;
        off_nxt   = sv_off_r;
        cnt_nxt   = sv_blink_r ? (sv_lit_r ? sv_on_r : sv_off_r) : '0;
      end else if (blink_fire) begin
        lit_nxt = !lit_r;
        // an earlier reload in the same tick picks the interval of the old state
        cnt_nxt = ctl.pre_sw ? (lit_r ? on_r : off_r) : (lit_r ? off_r : on_r);
      end else begin
        cnt_nxt = (cnt_r != '0) ? cnt_r - ONE : '0;
      end
    end else if (ctl.sel) begin
      if (ctl.kind == bmc_pkg::ACT_ON) begin
        lit_nxt = 1'b1;
      end else if (ctl.kind == bmc_pkg::ACT_OFF) begin
        lit_nxt = 1'b0;
      end else begin
        lit_nxt = !lit_r;
      end
      blink_nxt = (ctl.kind == bmc_pkg::ACT_BLINK);
      on_nxt    = on_t;
      off_nxt   = off_t;
      if (dur == '0) begin
        sv_lit_nxt   = lit_nxt;
        sv_blink_nxt = blink_nxt;
        sv_on_nxt    = on_t;
        sv_off_nxt   = off_t;
      end
      // a running blink interval keeps its count
      if (blink_nxt) begin
        cnt_nxt = (cnt_r == '0) ? (lit_nxt ? on_t : off_t) : cnt_r;
      end else begin
        cnt_nxt = '0;
      end
      hold_nxt = dur;
    end
  end

  assign sts.hold_fire  = hold_fire;
  assign sts.blink_fire = blink_fire;
  assign sts.lit_nxt    = lit_nxt;
  assign sts.blink_nxt  = blink_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r      <= 1'b1;
      blink_r    <= 1'b0;
      on_r       <= '0;
      off_r      <= '0;
      sv_lit_r   <= 1'b1;
      sv_blink_r <= 1'b0;
      sv_on_r    <= '0;
      sv_off_r   <= '0;
      hold_r     <= '0;
      cnt_r      <= '0;
    end else if (upd) begin
      lit_r      <= lit_nxt;
      blink_r    <= blink_nxt;
      on_r       <= on_nxt;
      off_r      <= off_nxt;
      sv_lit_r   <= sv_lit_nxt;
      sv_blink_r <= sv_blink_nxt;
      sv_on_r    <= sv_on_nxt;
      sv_off_r   <= sv_off_nxt;
      hold_r     <= hold_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

// ----- design/bmc_bright.sv -----
module bmc_bright #(
  parameter int TIMER_BITS = bmc_pkg::TIMER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     upd,
  input  logic                     tick,
  input  logic                     set,
  input  logic [4:0]               level,
  input  logic [TIMER_BITS-1:0]    dur,
  input  logic                     cfg_we,
  input  logic [6:0]               cfg_wdata,
  output bmc_pkg::bmc_bright_sts_t sts
);

  localparam logic [TIMER_BITS-1:0] ONE = TIMER_BITS'(1);

  logic [6:0]            now_r, now_nxt;
  logic [6:0]            saved_r, saved_nxt;
  logic [TIMER_BITS-1:0] hold_r, hold_nxt;
  logic [TIMER_BITS-1:0] dur_eff;
  logic [6:0]            raw;
  logic                  hold_fire;

  assign hold_fire = (hold_r == ONE);

  always_comb begin
    now_nxt   = now_r;
    saved_nxt = saved_r;
    hold_nxt  = hold_r;
    dur_eff   = dur;
    raw       = bmc_pkg::RAW_FALLBACK;
    if (tick) begin
      hold_nxt = (hold_r != '0) ? hold_r - ONE : '0;
      if (hold_fire) begin
        now_nxt = saved_r;
      end
    end else if (set) begin
      // level zero restores the saved value as a permanent setting
      if (level == 5'd0) begin
        raw     = saved_r;
        dur_eff = '0;
      end else if (level <= 5'(bmc_pkg::LEVEL_COUNT)) begin
        raw = bmc_pkg::level_to_raw(4'(level - 5'd1));
      end
      now_nxt = raw;
      if (dur_eff == '0) begin
        saved_nxt = raw;
      end
      hold_nxt = dur_eff;
    end
  end

  assign sts.hold_fire = hold_fire;
  assign sts.raw_nxt   = now_nxt;
  assign sts.step_nxt  = bmc_pkg::raw_to_step(now_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r   <= bmc_pkg::RAW_RESET;
      saved_r <= bmc_pkg::RAW_RESET;
      hold_r  <= '0;
    end else if (cfg_we) begin
      now_r   <= cfg_wdata;
      saved_r <= cfg_wdata;
    end else if (upd) begin
      now_r   <= now_nxt;
      saved_r <= saved_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

// ----- design/backlight_mode_controller_unit.sv -----
// Backlight mode controller: screen and keys backlight channels plus screen
// brightness. Each command item (tick, on, off, blink, toggle, set level)
// gives exactly one result item with both channel states, blink flags, raw
// brightness, its readback step and an error code. An item waits in an input
// register until the result register is free; the whole state update is one
// pass of mux and decrement logic into the state and result registers, so
// the block takes one item per cycle; only a stalled result register holds
// the input side back. The cfg port loads the current and saved brightness;
// the user must see that it is written while no item is in flight, as the
// block itself does not enforce it. No clearing pass is needed after reset.
module backlight_mode_controller_unit #(
  parameter int TIMER_BITS = bmc_pkg::TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [6:0]       cfg_wdata,
  bmc_in_if.sink           in_ch,
  bmc_out_if.source        out_ch
);

  // largest count a timer holds; longer requests saturate to it
  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  function automatic logic [TIMER_BITS-1:0] sat_cnt(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > TIMER_MAX) begin
      return TIMER_BITS'(TIMER_MAX);
    end
    return TIMER_BITS'(w);
  endfunction

  // input register stage
  bmc_pkg::bmc_in_t  in_r;
  logic              in_vld_r;
  // result register stage
  bmc_pkg::bmc_out_t out_r, out_nxt;
  logic              out_vld_r;

  logic s_fire;

  // decode
  logic [2:0]            act;
  logic [1:0]            tgt;
  logic                  is_tick;
  logic                  is_chan_cmd;
  logic                  bad_blink;
  logic                  cmd_ok;
  logic [TIMER_BITS-1:0] dur_s;
  logic [TIMER_BITS-1:0] on_s;
  logic [TIMER_BITS-1:0] off_s;
  logic [1:0]            err;

  bmc_pkg::bmc_chan_ctl_t   scr_ctl, keys_ctl;
  bmc_pkg::bmc_chan_sts_t   scr_sts, keys_sts;
  bmc_pkg::bmc_bright_sts_t br_sts;

  // the item in the input register moves on when the result register frees
  assign s_fire      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || s_fire;

  assign act = in_r.action;
  assign tgt = in_r.target;

  assign is_tick     = (act == bmc_pkg::ACT_TICK);
  assign is_chan_cmd = (act == bmc_pkg::ACT_ON) || (act == bmc_pkg::ACT_OFF) ||
                       (act == bmc_pkg::ACT_BLINK) || (act == bmc_pkg::ACT_TOGGLE);
  // zero interval rejects the blink whatever the target
  assign bad_blink   = (act == bmc_pkg::ACT_BLINK) &&
                       ((in_r.on_time == 16'd0) || (in_r.off_time == 16'd0));
  assign cmd_ok      = is_chan_cmd && !bad_blink && (tgt != bmc_pkg::TGT_NONE);

  assign dur_s = sat_cnt(in_r.duration);
  // only a blink carries intervals, everything else clears them
  assign on_s  = (act == bmc_pkg::ACT_BLINK) ? sat_cnt(in_r.on_time) : '0;
  assign off_s = (act == bmc_pkg::ACT_BLINK) ? sat_cnt(in_r.off_time) : '0;

  always_comb begin
    priority if (bad_blink) begin
      err = bmc_pkg::ERR_BLINK_ARG;
    end else if (is_chan_cmd && (tgt == bmc_pkg::TGT_NONE)) begin
      err = bmc_pkg::ERR_TARGET;
    end else begin
      err = bmc_pkg::ERR_OK;
    end
  end

  // within one tick every fall-back reloads idle blinkers before any blink
  // toggle, and a screen toggle reloads the keys ahead of their own toggle
  assign scr_ctl.tick    = is_tick;
  assign scr_ctl.sel     = cmd_ok && ((tgt == bmc_pkg::TGT_SCREEN) ||
                                      (tgt == bmc_pkg::TGT_BOTH));
  assign scr_ctl.kind    = act;
  assign scr_ctl.pre_sw  = keys_sts.hold_fire || br_sts.hold_fire;

  assign keys_ctl.tick   = is_tick;
  assign keys_ctl.sel    = cmd_ok && ((tgt == bmc_pkg::TGT_KEYS) ||
                                      (tgt == bmc_pkg::TGT_BOTH));
  assign keys_ctl.kind   = act;
  assign keys_ctl.pre_sw = scr_sts.hold_fire || br_sts.hold_fire || scr_sts.blink_fire;

  bmc_chan #(
    .TIMER_BITS (TIMER_BITS)
  ) u_scr (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s_fire),
    .ctl   (scr_ctl),
    .dur   (dur_s),
    .on_t  (on_s),
    .off_t (off_s),
    .sts   (scr_sts)
  );

  bmc_chan #(
    .TIMER_BITS (TIMER_BITS)
  ) u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s_fire),
    .ctl   (keys_ctl),
    .dur   (dur_s),
    .on_t  (on_s),
    .off_t (off_s),
    .sts   (keys_sts)
  );

  // set level ignores the target field
  bmc_bright #(
    .TIMER_BITS (TIMER_BITS)
  ) u_bright (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s_fire),
    .tick      (is_tick),
    .set       (act == bmc_pkg::ACT_LEVEL),
    .level     (in_r.level),
    .dur       (dur_s),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (br_sts)
  );

  // result shows the state after the item
  always_comb begin
    out_nxt.screen_lit      = scr_sts.lit_nxt;
    out_nxt.keys_lit        = keys_sts.lit_nxt;
    out_nxt.screen_blinking = scr_sts.blink_nxt;
    out_nxt.keys_blinking   = keys_sts.blink_nxt;
    out_nxt.brightness_raw  = br_sts.raw_nxt;
    out_nxt.brightness_step = br_sts.step_nxt;
    out_nxt.error_code      = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (s_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
    if (s_fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

endmodule

// ----- design/bmc_checker.sv -----
module bmc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input bmc_pkg::bmc_out_t out_data
);

  // only the three defined error codes appear
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error_code == bmc_pkg::ERR_OK) ||
                  (out_data.error_code == bmc_pkg::ERR_BLINK_ARG) ||
                  (out_data.error_code == bmc_pkg::ERR_TARGET))
    else $error("bmc: undefined error code");

  // readback table never yields level zero
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.brightness_step != 5'd0)
    else $error("bmc: brightness step zero");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("bmc: stalled result changed");

  // a fresh result follows an accepted item
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("bmc: result without an item");

  // an empty result stage never stalls the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("bmc: input stalled with empty result stage");

endmodule

bind backlight_mode_controller_unit bmc_checker u_bmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- sim/tb_backlight_mode_controller_unit.sv -----
`timescale 1ns / 100ps

module tb_backlight_mode_controller_unit;

  // watchdog and pacing limits, in clock cycles
  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASE_ITEMS     = 455;
  localparam int HOLD_OFF_AFTER  = 900;

  // action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // channel slots in the predictor, brightness takes the third hold counter
  localparam int CH_SCREEN = 0;
  localparam int CH_KEYS   = 1;
  localparam int CH_BRIGHT = 2;

  // level to raw table and readback floors, entry 0 in the low bits
  localparam logic [16*7-1:0] LEVEL_RAW = {
    7'd100, 7'd89, 7'd83, 7'd77, 7'd71, 7'd65, 7'd59, 7'd53,
    7'd47, 7'd41, 7'd35, 7'd29, 7'd23, 7'd17, 7'd13, 7'd0};
  localparam logic [16*7-1:0] STEP_FLOOR = {
    7'd90, 7'd84, 7'd78, 7'd72, 7'd66, 7'd60, 7'd54, 7'd48,
    7'd42, 7'd36, 7'd30, 7'd24, 7'd18, 7'd14, 7'd13, 7'd0};

  typedef struct packed {
    logic        lit;
    logic        blink;
    logic [15:0] on_t;
    logic [15:0] off_t;
  } lamp_mode_t;

  // what the monitor needs to know about each offered command item
  typedef struct packed {
    logic              typed;
    bmc_pkg::bmc_out_t want;
  } cmd_note_t;

  typedef struct {
    bmc_pkg::bmc_in_t  cmd;
    logic              typed;
    bmc_pkg::bmc_out_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  bmc_in_if  cmd_if ();
  bmc_out_if stat_if ();

  backlight_mode_controller_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (cmd_if),
    .out_ch    (stat_if)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted controller state
  lamp_mode_t  live_mode [2];
  lamp_mode_t  home_mode [2];
  logic [15:0] hold_cnt [3];
  logic [15:0] blink_cnt [2];
  logic [6:0]  bright_live;
  logic [6:0]  bright_home;

  // scoreboard
  bmc_pkg::bmc_out_t status_due [$];
  cmd_note_t         cmd_notes [$];
  plan_row_t         opening_plan [$];
  int                fail_count = 0;
  int                results_seen = 0;
  bit                steady_flow = 1'b0;
  bit                held_once = 1'b0;

  cmd_note_t         note_now;
  bmc_pkg::bmc_out_t due_now;
  bmc_pkg::bmc_out_t calc_now;

  function automatic void reset_predictor();
    for (int c = 0; c < 2; c++) begin
      live_mode[c] = '0;
      live_mode[c].lit = 1'b1;
      home_mode[c] = live_mode[c];
      blink_cnt[c] = '0;
    end
    for (int c = 0; c < 3; c++) begin
      hold_cnt[c] = '0;
    end
    bright_live = bmc_pkg::RAW_RESET;
    bright_home = bmc_pkg::RAW_RESET;
  endfunction

  // reload an idle blink counter with the interval of the current phase, clear it when not blinking
  function automatic void rearm_blinkers();
    for (int c = 0; c < 2; c++) begin
      if (!live_mode[c].blink) begin
        blink_cnt[c] = '0;
      end else if (blink_cnt[c] == 0) begin
        blink_cnt[c] = live_mode[c].lit ? live_mode[c].on_t : live_mode[c].off_t;
      end
    end
  endfunction

  function automatic void set_channel(int c, logic [2:0] act, logic [15:0] dur,
                                      logic [15:0] on_t, logic [15:0] off_t);
    case (act)
      bmc_pkg::ACT_ON:  live_mode[c].lit = 1'b1;
      bmc_pkg::ACT_OFF: live_mode[c].lit = 1'b0;
      default:          live_mode[c].lit = ~live_mode[c].lit;
    endcase
    live_mode[c].blink = (act == bmc_pkg::ACT_BLINK) && (on_t != 0);
    live_mode[c].on_t  = on_t;
    live_mode[c].off_t = off_t;
    // a permanent command also becomes the fall-back setting
    if (dur == 0) begin
      home_mode[c] = live_mode[c];
    end
  endfunction

  function automatic void tick_timers();
    logic hold_fire [3];
    logic blink_fire [2];
    for (int c = 0; c < 3; c++) begin
      hold_fire[c] = 1'b0;
      if (hold_cnt[c] != 0) begin
        hold_cnt[c] = hold_cnt[c] - 16'd1;
        hold_fire[c] = (hold_cnt[c] == 0);
      end
    end
    for (int c = 0; c < 2; c++) begin
      blink_fire[c] = 1'b0;
      if (blink_cnt[c] != 0) begin
        blink_cnt[c] = blink_cnt[c] - 16'd1;
        blink_fire[c] = (blink_cnt[c] == 0);
      end
    end
    // fall-backs first, and they swallow a blink expiry of the same tick
    for (int c = 0; c < 2; c++) begin
      if (hold_fire[c]) begin
        blink_cnt[c] = '0;
        blink_fire[c] = 1'b0;
        live_mode[c] = home_mode[c];
        rearm_blinkers();
      end
    end
    if (hold_fire[CH_BRIGHT]) begin
      bright_live = bright_home;
      rearm_blinkers();
    end
    for (int c = 0; c < 2; c++) begin
      if (blink_fire[c]) begin
        live_mode[c].lit = ~live_mode[c].lit;
        rearm_blinkers();
      end
    end
  endfunction

  // highest readback floor not above the raw value
  function automatic logic [4:0] step_of(logic [6:0] raw);
    logic [4:0] s;
    s = 5'd1;
    for (int i = 0; i < 16; i++) begin
      if (raw >= STEP_FLOOR[i*7 +: 7]) begin
        s = 5'(i + 1);
      end
    end
    return s;
  endfunction

  // apply one command item, return the status item it should produce
  function automatic bmc_pkg::bmc_out_t advance_controller(bmc_pkg::bmc_in_t c);
    bmc_pkg::bmc_out_t r;
    logic [1:0]        err;
    logic [15:0]       dur;
    logic [15:0]       on_t;
    logic [15:0]       off_t;
    logic [6:0]        raw;
    int                idx;
    err   = bmc_pkg::ERR_OK;
    dur   = c.duration;
    on_t  = c.on_time;
    off_t = c.off_time;
    case (c.action)
      bmc_pkg::ACT_TICK: begin
        tick_timers();
      end
      bmc_pkg::ACT_ON, bmc_pkg::ACT_OFF, bmc_pkg::ACT_BLINK, bmc_pkg::ACT_TOGGLE: begin
        if (c.action == bmc_pkg::ACT_BLINK && (on_t == 0 || off_t == 0)) begin
          err = bmc_pkg::ERR_BLINK_ARG;
        end else begin
          if (c.action != bmc_pkg::ACT_BLINK) begin
            on_t  = '0;
            off_t = '0;
          end
          if (c.target == bmc_pkg::TGT_SCREEN || c.target == bmc_pkg::TGT_BOTH) begin
            set_channel(CH_SCREEN, c.action, dur, on_t, off_t);
          end
          if (c.target == bmc_pkg::TGT_KEYS || c.target == bmc_pkg::TGT_BOTH) begin
            set_channel(CH_KEYS, c.action, dur, on_t, off_t);
          end
          rearm_blinkers();
          if (c.target == bmc_pkg::TGT_SCREEN || c.target == bmc_pkg::TGT_BOTH) begin
            hold_cnt[CH_SCREEN] = dur;
          end
          if (c.target == bmc_pkg::TGT_KEYS || c.target == bmc_pkg::TGT_BOTH) begin
            hold_cnt[CH_KEYS] = dur;
          end
          if (c.target == bmc_pkg::TGT_NONE) begin
            err = bmc_pkg::ERR_TARGET;
          end
        end
      end
      bmc_pkg::ACT_LEVEL: begin
        raw = bmc_pkg::RAW_FALLBACK;
        idx = int'(c.level) - 1;
        if (c.level == 0) begin
          raw = bright_home;
          dur = '0;
        end else if (c.level <= 16) begin
          raw = LEVEL_RAW[idx*7 +: 7];
        end
        bright_live = raw;
        if (dur == 0) begin
          bright_home = raw;
        end
        rearm_blinkers();
        hold_cnt[CH_BRIGHT] = dur;
      end
      default: begin
      end
    endcase
    r.screen_lit      = live_mode[CH_SCREEN].lit;
    r.keys_lit        = live_mode[CH_KEYS].lit;
    r.screen_blinking = live_mode[CH_SCREEN].blink;
    r.keys_blinking   = live_mode[CH_KEYS].blink;
    r.brightness_raw  = bright_live;
    r.brightness_step = step_of(bright_live);
    r.error_code      = err;
    return r;
  endfunction

  function automatic bmc_pkg::bmc_out_t lamps(logic sl, logic kl, logic sb, logic kb,
                                              logic [6:0] raw, logic [4:0] step,
                                              logic [1:0] err);
    bmc_pkg::bmc_out_t r;
    r.screen_lit      = sl;
    r.keys_lit        = kl;
    r.screen_blinking = sb;
    r.keys_blinking   = kb;
    r.brightness_raw  = raw;
    r.brightness_step = step;
    r.error_code      = err;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] act, logic [1:0] tgt, logic [15:0] dur,
                                  logic [15:0] on_t, logic [15:0] off_t, logic [4:0] lvl,
                                  logic typed, bmc_pkg::bmc_out_t want);
    plan_row_t row;
    row.cmd.action   = act;
    row.cmd.target   = tgt;
    row.cmd.duration = dur;
    row.cmd.on_time  = on_t;
    row.cmd.off_time = off_t;
    row.cmd.level    = lvl;
    row.typed        = typed;
    row.want         = want;
    opening_plan.push_back(row);
  endfunction

  // directed opening: reset state, error codes, level extremes, fall-backs
  function automatic void build_opening_plan();
    bmc_pkg::bmc_out_t at_reset;
    bmc_pkg::bmc_out_t none;
    at_reset = lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_RESET, 5'd10, bmc_pkg::ERR_OK);
    none = '0;
    // plain tick right after reset
    add_row(bmc_pkg::ACT_TICK, bmc_pkg::TGT_SCREEN, 16'd0, 16'd0, 16'd0, 5'd0,
            1'b1, at_reset);
    // blink with a zero interval is refused and changes nothing
    add_row(bmc_pkg::ACT_BLINK, bmc_pkg::TGT_SCREEN, 16'd0, 16'd0, 16'd5, 5'd0, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_RESET, 5'd10,
                  bmc_pkg::ERR_BLINK_ARG));
    add_row(bmc_pkg::ACT_BLINK, bmc_pkg::TGT_BOTH, 16'hFFFF, 16'hFFFF, 16'd0, 5'd31, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_RESET, 5'd10,
                  bmc_pkg::ERR_BLINK_ARG));
    // unsupported target, for a plain command and a valid blink
    add_row(bmc_pkg::ACT_ON, bmc_pkg::TGT_NONE, 16'd0, 16'd0, 16'd0, 5'd0, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_RESET, 5'd10, bmc_pkg::ERR_TARGET));
    add_row(bmc_pkg::ACT_BLINK, bmc_pkg::TGT_NONE, 16'd0, 16'd3, 16'd3, 5'd0, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_RESET, 5'd10, bmc_pkg::ERR_TARGET));
    // level extremes, target ignored
    add_row(bmc_pkg::ACT_LEVEL, bmc_pkg::TGT_NONE, 16'd0, 16'd0, 16'd0, 5'd16, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, 7'd100, 5'd16, bmc_pkg::ERR_OK));
    add_row(bmc_pkg::ACT_LEVEL, bmc_pkg::TGT_SCREEN, 16'd0, 16'd0, 16'd0, 5'd1, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, 7'd0, 5'd1, bmc_pkg::ERR_OK));
    add_row(bmc_pkg::ACT_LEVEL, bmc_pkg::TGT_KEYS, 16'd0, 16'd0, 16'd0, 5'd31, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_FALLBACK, 5'd10, bmc_pkg::ERR_OK));
    add_row(bmc_pkg::ACT_LEVEL, bmc_pkg::TGT_BOTH, 16'hFFFF, 16'd0, 16'd0, 5'd17, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_FALLBACK, 5'd10, bmc_pkg::ERR_OK));
    // level 0 restores the saved value and drops the pending revert
    add_row(bmc_pkg::ACT_LEVEL, bmc_pkg::TGT_SCREEN, 16'd5, 16'd0, 16'd0, 5'd0, 1'b1,
            lamps(1'b1, 1'b1, 1'b0, 1'b0, bmc_pkg::RAW_FALLBACK, 5'd10, bmc_pkg::ERR_OK));
    // unused action with every field at its top
    add_row(ACT_SPARE_HI, bmc_pkg::TGT_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31,
            1'b0, none);
    add_row(bmc_pkg::ACT_OFF, bmc_pkg::TGT_SCREEN, 16'd0, 16'd0, 16'd0, 5'd0, 1'b0, none);
    // temporary toggle on keys that falls back after three ticks
    add_row(bmc_pkg::ACT_TOGGLE, bmc_pkg::TGT_KEYS, 16'd3, 16'd0, 16'd0, 5'd0, 1'b0, none);
    repeat (3) add_row(bmc_pkg::ACT_TICK, bmc_pkg::TGT_SCREEN, 16'd0, 16'd0, 16'd0, 5'd0,
                       1'b0, none);
    // permanent blink on both channels
    add_row(bmc_pkg::ACT_BLINK, bmc_pkg::TGT_BOTH, 16'd0, 16'd2, 16'd1, 5'd0, 1'b0, none);
    repeat (3) add_row(bmc_pkg::ACT_TICK, bmc_pkg::TGT_KEYS, 16'd0, 16'd0, 16'd0, 5'd0,
                       1'b0, none);
    // fall-back and blink expiry land on the same tick
    add_row(bmc_pkg::ACT_BLINK, bmc_pkg::TGT_SCREEN, 16'd2, 16'd2, 16'd2, 5'd0, 1'b0, none);
    repeat (2) add_row(bmc_pkg::ACT_TICK, bmc_pkg::TGT_BOTH, 16'd0, 16'd0, 16'd0, 5'd0,
                       1'b0, none);
    // temporary brightness that reverts on the next tick
    add_row(bmc_pkg::ACT_LEVEL, bmc_pkg::TGT_SCREEN, 16'd1, 16'd0, 16'd0, 5'd8, 1'b0, none);
    add_row(bmc_pkg::ACT_TICK, bmc_pkg::TGT_NONE, 16'd0, 16'd0, 16'd0, 5'd0, 1'b0, none);
    add_row(bmc_pkg::ACT_ON, bmc_pkg::TGT_BOTH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31,
            1'b0, none);
  endfunction

  // mostly short durations and intervals so the timers really fire
  function automatic logic [15:0] random_span(int zero_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < zero_pct) begin
      return '0;
    end
    if (pick < 88) begin
      return 16'($urandom_range(1, 8));
    end
    return 16'($urandom);
  endfunction

  function automatic bmc_pkg::bmc_in_t random_cmd();
    bmc_pkg::bmc_in_t c;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      c.action = bmc_pkg::ACT_TICK;
    end else if (pick < 85) begin
      c.action = 3'($urandom_range(bmc_pkg::ACT_ON, bmc_pkg::ACT_TOGGLE));
    end else if (pick < 95) begin
      c.action = bmc_pkg::ACT_LEVEL;
    end else begin
      c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    c.target = ($urandom_range(9) == 0) ? bmc_pkg::TGT_NONE
               : 2'($urandom_range(bmc_pkg::TGT_SCREEN, bmc_pkg::TGT_BOTH));
    c.duration = random_span(35);
    c.on_time  = random_span(5);
    c.off_time = random_span(5);
    c.level    = ($urandom_range(99) < 75) ? 5'($urandom_range(0, 16))
                                           : 5'($urandom_range(0, 31));
    return c;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_status(bmc_pkg::bmc_out_t want, bmc_pkg::bmc_out_t got);
    check_field("screen_lit", want.screen_lit, got.screen_lit);
    check_field("keys_lit", want.keys_lit, got.keys_lit);
    check_field("screen_blinking", want.screen_blinking, got.screen_blinking);
    check_field("keys_blinking", want.keys_blinking, got.keys_blinking);
    check_field("brightness_raw", want.brightness_raw, got.brightness_raw);
    check_field("brightness_step", want.brightness_step, got.brightness_step);
    check_field("error_code", want.error_code, got.error_code);
  endtask

  // offer one command item from a falling edge, return at the falling edge
  // after it was taken; valid stays up so back-to-back items need no gap
  task automatic offer_cmd(bmc_pkg::bmc_in_t c, logic typed, bmc_pkg::bmc_out_t want);
    cmd_note_t n;
    n.typed = typed;
    n.want  = want;
    while (!steady_flow && $urandom_range(99) < 33) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_notes.push_back(n);
    cmd_if.valid = 1'b1;
    cmd_if.data  = c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sender idles until every pending status item has come back
  task automatic drain_results();
    cmd_if.valid = 1'b0;
    while (status_due.size() != 0) @(negedge clk);
  endtask

  // new default brightness, written only with nothing in flight
  task automatic load_default(logic [6:0] value);
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we      = 1'b0;
    bright_live = value;
    bright_home = value;
  endtask

  // random phase; ignored actions do not count toward the item total
  task automatic run_random(int count, int gapless, int pause_at);
    bmc_pkg::bmc_in_t c;
    int               done;
    done = 0;
    while (done < count) begin
      steady_flow = (done < gapless);
      if (done == pause_at) begin
        drain_results();
      end
      c = random_cmd();
      offer_cmd(c, 1'b0, '0);
      if (c.action <= bmc_pkg::ACT_LEVEL) begin
        done++;
      end
    end
    steady_flow = 1'b0;
  endtask

  // monitor: score returned status items, predict for each taken command item
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (stat_if.valid && stat_if.ready) begin
        results_seen++;
        if (status_due.size() == 0) begin
          $error("status item with nothing pending");
          fail_count++;
        end else begin
          due_now = status_due.pop_front();
          compare_status(due_now, stat_if.data);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        note_now = cmd_notes.pop_front();
        calc_now = advance_controller(cmd_if.data);
        // directed rows with a typed value are held to that value
        status_due.push_back(note_now.typed ? note_now.want : calc_now);
      end
    end
  end

  // status side: random stalls, one long hold-off that backs up the block
  initial begin
    stat_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= HOLD_OFF_AFTER) begin
        held_once     = 1'b1;
        stat_if.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      stat_if.ready = steady_flow || ($urandom_range(99) >= 33);
    end
  end

  // watchdog on cycles in which neither side moves an item
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (stat_if.valid && stat_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_backlight_mode_controller_unit NOT OK");
    $finish;
  end

  // stimulus: reset, directed opening, then random phases at several defaults
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    reset_predictor();
    build_opening_plan();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (opening_plan[i]) begin
      offer_cmd(opening_plan[i].cmd, opening_plan[i].typed, opening_plan[i].want);
    end

    // lowest default
    load_default(7'd0);
    run_random(PHASE_ITEMS, 0, -1);
    // highest default, opening stretch without any idling
    load_default(7'd100);
    run_random(PHASE_ITEMS, 300, -1);
    // some middle value, with one full drain partway through
    load_default(7'($urandom_range(1, 99)));
    run_random(PHASE_ITEMS, 0, 200);
    // back to the reset value
    load_default(bmc_pkg::RAW_RESET);
    run_random(PHASE_ITEMS, 0, -1);

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_backlight_mode_controller_unit OK");
    end else begin
      $display("tb_backlight_mode_controller_unit NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bmc_pkg.sv
design/bmc_if.sv
design/bmc_chan.sv
design/bmc_bright.sv
design/backlight_mode_controller_unit.sv
design/bmc_checker.sv
sim/tb_backlight_mode_controller_unit.sv
